// ===== sv/ror_pkg.sv =====
// Shared types, register codes and a helper function of the relay output register controller.
package ror_pkg;

    // Number of relays that the request mask lets through.
    localparam int RELAY_COUNT = 8;
    localparam logic [7:0] RELAY_MASK = 8'(((1 << RELAY_COUNT) - 1) & 'hFF);

    localparam logic [15:0] MS_MAX = 16'hFFFF;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_APPLY_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_PERIOD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOSS_TIMEOUT = 2'd2;

    localparam logic [15:0] APPLY_PERIOD_RESET = 16'd100;
    localparam logic [15:0] CHECK_PERIOD_RESET = 16'd500;
    localparam logic [15:0] LOSS_TIMEOUT_RESET = 16'd10000;

    // Item kinds.
    localparam logic MODE_ACCESS = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // Register map addresses.
    localparam logic [15:0] ADDR_RELAY        = 16'd0;
    localparam logic [15:0] ADDR_RELAY_MIRROR = 16'd1;
    localparam logic [15:0] ADDR_ERROR        = 16'd3;
    localparam logic [15:0] ADDR_SERVICE      = 16'd580;
    localparam logic [15:0] ADDR_SERVICE_A    = 16'd590;
    localparam logic [15:0] ADDR_SERVICE_B    = 16'd591;
    localparam logic [15:0] ADDR_SERVICE_C    = 16'd592;
    localparam logic [15:0] ADDR_SERVICE_D    = 16'd593;
    localparam logic [15:0] ADDR_REBOOT       = 16'd594;
    localparam logic [15:0] ADDR_BOOTLOADER   = 16'd900;

    localparam logic signed [15:0] READ_NONE    = 16'sd0;
    localparam logic signed [15:0] READ_UNKNOWN = -16'sd1;

    typedef struct packed {
        logic [15:0] apply_period_ms;
        logic [15:0] check_period_ms;
        logic [15:0] loss_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic               mode;
        logic [15:0]        reg_addr;
        logic               is_write;
        logic signed [15:0] write_value;
    } item_t;

    typedef struct packed {
        logic signed [15:0] read_data;
        logic [7:0]         relay_outputs;
        logic               status_led;
        logic               reboot_request;
        logic               bootloader_request;
    } result_t;

    typedef struct packed {
        logic [7:0]  requested_relays;
        logic [7:0]  applied_relays;
        logic        link_up;
        logic        led_level;
        logic        reboot_pending;
        logic [15:0] ms_since_apply;
        logic [15:0] ms_since_check;
        logic [15:0] ms_since_access;
    } state_t;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == MS_MAX) ? MS_MAX : v + 16'd1;
    endfunction

endpackage

// ===== sv/ror_if.sv =====
// Handshake channels for command items and result items.
interface ror_cmd_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [15:0]        reg_addr;
    logic               is_write;
    logic signed [15:0] write_value;

    modport source (output valid, output mode, output reg_addr, output is_write,
                    output write_value, input ready);
    modport sink (input valid, input mode, input reg_addr, input is_write,
                  input write_value, output ready);
endinterface

interface ror_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] read_data;
    logic [7:0]         relay_outputs;
    logic               status_led;
    logic               reboot_request;
    logic               bootloader_request;

    modport source (output valid, output read_data, output relay_outputs,
                    output status_led, output reboot_request,
                    output bootloader_request, input ready);
    modport sink (input valid, input read_data, input relay_outputs,
                  input status_led, input reboot_request,
                  input bootloader_request, output ready);
endinterface

// ===== sv/ror_cfg.sv =====
// Configuration registers with their reset values.
module ror_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             we,
    input  logic [ror_pkg::CFG_INDEX_W-1:0]  index,
    input  logic [15:0]                      wdata,
    output ror_pkg::cfg_t                    cfg
);

    ror_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.apply_period_ms <= ror_pkg::APPLY_PERIOD_RESET;
            cfg_reg.check_period_ms <= ror_pkg::CHECK_PERIOD_RESET;
            cfg_reg.loss_timeout_ms <= ror_pkg::LOSS_TIMEOUT_RESET;
        end
        else if (we)
        begin
            case (index)
                ror_pkg::CFG_APPLY_PERIOD: cfg_reg.apply_period_ms <= wdata;
                ror_pkg::CFG_CHECK_PERIOD: cfg_reg.check_period_ms <= wdata;
                ror_pkg::CFG_LOSS_TIMEOUT: cfg_reg.loss_timeout_ms <= wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/ror_core.sv =====
// Next-state and result logic for one command item.
module ror_core (
    input  ror_pkg::cfg_t    cfg,
    input  ror_pkg::state_t  cur,
    input  ror_pkg::item_t   item,
    output ror_pkg::state_t  nxt,
    output ror_pkg::result_t res
);

    always_comb
    begin
        nxt                    = cur;
        res.read_data          = ror_pkg::READ_NONE;
        res.reboot_request     = 1'b0;
        res.bootloader_request = 1'b0;

        if (item.mode == ror_pkg::MODE_TICK)
        begin
            nxt.ms_since_apply  = ror_pkg::sat_inc(cur.ms_since_apply);
            nxt.ms_since_check  = ror_pkg::sat_inc(cur.ms_since_check);
            nxt.ms_since_access = ror_pkg::sat_inc(cur.ms_since_access);

            // The apply step copies the request as it stood before this tick.
            if (nxt.ms_since_apply >= cfg.apply_period_ms)
            begin
                nxt.ms_since_apply = '0;
                nxt.applied_relays = cur.requested_relays;
                if (cur.reboot_pending)
                begin
                    res.reboot_request = 1'b1;
                    nxt.reboot_pending = 1'b0;
                end
            end

            if (nxt.ms_since_check >= cfg.check_period_ms)
            begin
                nxt.ms_since_check = '0;
                if (nxt.ms_since_access >= cfg.loss_timeout_ms)
                begin
                    nxt.link_up          = 1'b0;
                    nxt.requested_relays = '0;
                end
                if (!nxt.link_up)
                begin
                    nxt.led_level = ~cur.led_level;
                end
            end
        end
        else
        begin
            nxt.ms_since_access = '0;
            if (!cur.link_up)
            begin
                nxt.link_up   = 1'b1;
                nxt.led_level = 1'b1;
            end

            case (item.reg_addr)
                ror_pkg::ADDR_RELAY:
                begin
                    if (item.is_write)
                    begin
                        nxt.requested_relays = item.write_value[7:0] & ror_pkg::RELAY_MASK;
                    end
                    else
                    begin
                        res.read_data = {8'h00, cur.applied_relays};
                    end
                end
                ror_pkg::ADDR_RELAY_MIRROR: res.read_data = {8'h00, cur.applied_relays};
                ror_pkg::ADDR_ERROR,
                ror_pkg::ADDR_SERVICE,
                ror_pkg::ADDR_SERVICE_A,
                ror_pkg::ADDR_SERVICE_B,
                ror_pkg::ADDR_SERVICE_C,
                ror_pkg::ADDR_SERVICE_D: res.read_data = ror_pkg::READ_NONE;
                ror_pkg::ADDR_REBOOT: nxt.reboot_pending = 1'b1;
                ror_pkg::ADDR_BOOTLOADER: res.bootloader_request = 1'b1;
                default: res.read_data = ror_pkg::READ_UNKNOWN;
            endcase
        end

        res.relay_outputs = nxt.applied_relays;
        res.status_led    = nxt.led_level;
    end

endmodule

// ===== sv/relay_output_register_controller.sv =====
// Top level of the relay output register controller: input stage, state and result register.
//
//  channel  | direction | payload                                          | handshake
//  ---------+-----------+--------------------------------------------------+-------------
//  cmd      | in        | mode, reg_addr, is_write, write_value            | valid/ready
//  rsp      | out       | read_data, relay_outputs, status_led,            | valid/ready
//           |           | reboot_request, bootloader_request               |
//  cfg      | in        | cfg_we, cfg_index, cfg_wdata                     | write only
//
// One item is taken per clock cycle when the result side keeps up. An item
// is held in the input register, and its result is then registered in the
// result register. The state update and the result come from a single
// pass of the decode logic, so a following item sees the updated state
// without any extra wait.
// Reset clears the pipeline valid flags and all controller state, and loads
// the configuration registers with their default periods.
// When the result register is full and not taken, the input register holds
// its item and cmd.ready drops until the result moves on.
module relay_output_register_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    ror_cmd_if.sink                         cmd,
    ror_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [ror_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                     cfg_wdata
);

    ror_pkg::cfg_t    cfg;
    ror_pkg::state_t  state_reg;
    ror_pkg::state_t  state_next;
    ror_pkg::item_t   item_reg;
    ror_pkg::result_t result_reg;
    ror_pkg::result_t result_next;
    logic             item_valid_reg;
    logic             result_valid_reg;
    logic             advance;
    logic             accept;

    ror_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .wdata (cfg_wdata),
        .cfg   (cfg)
    );

    ror_core u_core (
        .cfg  (cfg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    // The held item moves into the result register whenever that register
    // is empty or is being emptied in this cycle.
    assign advance   = item_valid_reg && (!result_valid_reg || rsp.ready);
    assign cmd.ready = !item_valid_reg || advance;
    assign accept    = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                result_valid_reg <= 1'b1;
                state_reg        <= state_next;
            end
            else if (rsp.ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.mode        <= cmd.mode;
            item_reg.reg_addr    <= cmd.reg_addr;
            item_reg.is_write    <= cmd.is_write;
            item_reg.write_value <= cmd.write_value;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign rsp.valid              = result_valid_reg;
    assign rsp.read_data          = result_reg.read_data;
    assign rsp.relay_outputs      = result_reg.relay_outputs;
    assign rsp.status_led         = result_reg.status_led;
    assign rsp.reboot_request     = result_reg.reboot_request;
    assign rsp.bootloader_request = result_reg.bootloader_request;

endmodule

// ===== sv/ror_checker.sv =====
// Port-level assertions for the relay output register controller and their bind.
module ror_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic signed [15:0] rsp_read_data,
    input logic [7:0]         rsp_relay_outputs,
    input logic               rsp_status_led,
    input logic               rsp_reboot_request,
    input logic               rsp_bootloader_request
);

    // A stalled result keeps its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
        && $stable(rsp_relay_outputs) && $stable(rsp_status_led)
        && $stable(rsp_reboot_request) && $stable(rsp_bootloader_request))
        else $error("result changed while stalled");

    // A reboot is taken only on a tick and a bootloader request only on an access.
    a_req_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_reboot_request && rsp_bootloader_request))
        else $error("reboot and bootloader request in one item");

    // Neither request carries read data.
    a_req_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_reboot_request || rsp_bootloader_request)
        |-> rsp_read_data == 16'sd0)
        else $error("request item carries read data");

    // Relays beyond the relay count are never driven.
    a_relay_mask: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_relay_outputs & ~ror_pkg::RELAY_MASK) == 8'h00)
        else $error("relay driven beyond relay count");

endmodule

bind relay_output_register_controller ror_checker u_ror_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .rsp_valid              (rsp.valid),
    .rsp_ready              (rsp.ready),
    .rsp_read_data          (rsp.read_data),
    .rsp_relay_outputs      (rsp.relay_outputs),
    .rsp_status_led         (rsp.status_led),
    .rsp_reboot_request     (rsp.reboot_request),
    .rsp_bootloader_request (rsp.bootloader_request)
);
